@@ design/gjgp_pkg.sv @@
// Package for the greedy join group placer: payload structs, state encoding
// and the fixed widths and saturation limits of the cost arithmetic.
// Used by every module of the block; depends on nothing.
package gjgp_pkg;

  localparam int REC_W      = 10;
  localparam int LNODE_W    = 4;
  localparam int GROUP_SIZE = 8;
  localparam int GRP_IDX_W  = 3;
  localparam int MISS_W     = 4;
  localparam int NCFG_W     = 5;
  localparam int COEF_W     = 8;
  localparam int SIZE_W     = 16;
  localparam int JCOST_W    = 16;
  localparam int UNIT_W     = 24;
  localparam int REC_COST_W = 28;
  localparam int LOAD_W     = 31;
  localparam int COST_W     = 32;
  localparam int SUM_W      = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_NODES_IN_USE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_COEF      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_SIZE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JOIN_UNIT_COST = 2'd3;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  typedef struct packed {
    logic               op;
    logic [REC_W-1:0]   rec_a;
    logic [REC_W-1:0]   rec_b;
    logic [REC_W-1:0]   rec_c;
    logic [REC_W-1:0]   rec_d;
    logic [REC_W-1:0]   rec_e;
    logic [REC_W-1:0]   rec_f;
    logic [REC_W-1:0]   rec_g;
    logic [REC_W-1:0]   rec_h;
    logic [LNODE_W-1:0] load_node;
    logic               load_present;
  } in_item_t;

  typedef struct packed {
    logic [LNODE_W-1:0] chosen_node;
    logic [LOAD_W-1:0]  added_overhead;
    logic [SUM_W-1:0]   sum_overhead;
    logic [LOAD_W-1:0]  max_shuffle_load;
    logic [LOAD_W-1:0]  max_join_load;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_PL_RD,
    ST_PL_WAIT,
    ST_SCORE,
    ST_PL_WR,
    ST_UPDATE,
    ST_OUT
  } state_t;

endpackage

@@ design/greedy_join_group_placer.sv @@
// Greedy join group placer, top level: configuration registers, sequencer,
// cost state and result register.
// Depends on gjgp_pkg, gjgp_presence_mem, gjgp_load_mem and gjgp_score_unit.
//
// After reset the presence map is cleared one row per cycle, and no input is
// taken meanwhile; configuration writes are taken at any time. A load item
// reads and rewrites one presence row. A place item reads eight presence rows
// through the single memory port, scores the nodes one per cycle through a
// three-stage scoring pipeline, and writes the eight rows back with the
// winner's bit set. in_ready is high only between items; a result waits in
// the output register while the next item is taken.
module greedy_join_group_placer
  import gjgp_pkg::*;
#(
  parameter int MAX_NODES   = 16,
  parameter int NUM_RECORDS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NCNT_W = $clog2(MAX_NODES + 1);
  localparam int AW     = $clog2(NUM_RECORDS);

  state_t state_r;
  state_t state_nxt;

  logic [NCFG_W-1:0]  nodes_cfg_r;
  logic [COEF_W-1:0]  send_coef_r;
  logic [SIZE_W-1:0]  record_size_r;
  logic [JCOST_W-1:0] join_unit_r;
  logic [UNIT_W-1:0]  unit_r;
  logic [NCNT_W-1:0]  n_eff_r;
  logic [NCNT_W-1:0]  n_eff_nxt;

  in_item_t in_r;
  logic [GROUP_SIZE-1:0][REC_W-1:0] recs;
  logic [GROUP_SIZE-1:0]            rec_ok;

  logic [GRP_IDX_W-1:0] k_r;
  logic                 cap_v_r;
  logic [GRP_IDX_W-1:0] cap_k_r;
  logic                 cap_ok_r;
  logic [GROUP_SIZE-1:0][MAX_NODES-1:0] rows_r;

  logic                 pm_rd_en;
  logic [AW-1:0]        pm_rd_addr;
  logic [MAX_NODES-1:0] pm_rd_data;
  logic                 pm_wr_en;
  logic [AW-1:0]        pm_wr_addr;
  logic [MAX_NODES-1:0] pm_wr_data;
  logic                 pm_clr_busy;
  logic [MAX_NODES-1:0] load_bit;
  logic [MAX_NODES-1:0] best_bit;

  logic [NODE_W-1:0] lm_rd_addr;
  logic [LOAD_W-1:0] lm_rd_sh;
  logic [LOAD_W-1:0] lm_rd_jn;
  logic              lm_wr_en;

  logic              score_start;
  logic              score_done;
  logic [NODE_W-1:0] win_node;
  logic [COST_W-1:0] win_cost;
  logic [LOAD_W-1:0] best_sh;
  logic [LOAD_W-1:0] best_jn;

  logic [LOAD_W-1:0] max_sh_r;
  logic [LOAD_W-1:0] max_jn_r;
  logic [SUM_W-1:0]  sum_r;
  logic [LOAD_W-1:0] added_r;
  logic [LOAD_W-1:0] added;
  logic [SUM_W:0]    sum_wide;

  logic      out_valid_r;
  out_item_t out_r;
  logic      out_load;

  assign recs = {in_r.rec_h, in_r.rec_g, in_r.rec_f, in_r.rec_e,
                 in_r.rec_d, in_r.rec_c, in_r.rec_b, in_r.rec_a};

  always_comb begin
    for (int k = 0; k < GROUP_SIZE; k++) begin
      rec_ok[k] = (32'(recs[k]) < NUM_RECORDS);
    end
  end

  always_comb begin
    if (nodes_cfg_r == '0) begin
      n_eff_nxt = NCNT_W'(1);
    end else if (32'(nodes_cfg_r) > MAX_NODES) begin
      n_eff_nxt = NCNT_W'(MAX_NODES);
    end else begin
      n_eff_nxt = NCNT_W'(nodes_cfg_r);
    end
  end

  assign load_bit = MAX_NODES'(1) << in_r.load_node;
  assign best_bit = MAX_NODES'(1) << win_node;
  assign out_load = !out_valid_r || out_ready;

  assign added    = (win_cost > COST_W'(LOAD_MAX)) ? LOAD_MAX : win_cost[LOAD_W-1:0];
  assign sum_wide = {1'b0, sum_r} + (SUM_W + 1)'(added);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:   if (!pm_clr_busy) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.op == OP_PLACE) ? ST_PL_RD : ST_LD_RD;
        end
      end
      ST_LD_RD:   state_nxt = ST_LD_WR;
      ST_LD_WR:   state_nxt = ST_IDLE;
      ST_PL_RD:   if (k_r == GRP_IDX_W'(GROUP_SIZE - 1)) state_nxt = ST_PL_WAIT;
      ST_PL_WAIT: state_nxt = ST_SCORE;
      ST_SCORE:   if (score_done) state_nxt = ST_PL_WR;
      ST_PL_WR:   if (k_r == GRP_IDX_W'(GROUP_SIZE - 1)) state_nxt = ST_UPDATE;
      ST_UPDATE:  state_nxt = ST_OUT;
      ST_OUT:     if (out_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    pm_rd_en    = 1'b0;
    pm_rd_addr  = AW'(in_r.rec_a);
    pm_wr_en    = 1'b0;
    pm_wr_addr  = AW'(in_r.rec_a);
    pm_wr_data  = in_r.load_present ? (pm_rd_data | load_bit) : (pm_rd_data & ~load_bit);
    score_start = 1'b0;
    lm_wr_en    = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_LD_RD: pm_rd_en = 1'b1;
      ST_LD_WR: begin
        pm_wr_en = rec_ok[0] && (32'(in_r.load_node) < MAX_NODES);
      end
      ST_PL_RD: begin
        pm_rd_en   = 1'b1;
        pm_rd_addr = AW'(recs[k_r]);
      end
      ST_PL_WAIT: score_start = 1'b1;
      ST_PL_WR: begin
        pm_wr_en   = rec_ok[k_r];
        pm_wr_addr = AW'(recs[k_r]);
        pm_wr_data = rows_r[k_r] | best_bit;
      end
      ST_UPDATE: lm_wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      nodes_cfg_r   <= NCFG_W'(16);
      send_coef_r   <= COEF_W'(1);
      record_size_r <= SIZE_W'(1);
      join_unit_r   <= JCOST_W'(1);
      k_r           <= '0;
      cap_v_r       <= 1'b0;
      max_sh_r      <= '0;
      max_jn_r      <= '0;
      sum_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_NODES_IN_USE:   nodes_cfg_r   <= cfg_data[NCFG_W-1:0];
          CFG_SEND_COEF:      send_coef_r   <= cfg_data[COEF_W-1:0];
          CFG_RECORD_SIZE:    record_size_r <= cfg_data[SIZE_W-1:0];
          CFG_JOIN_UNIT_COST: join_unit_r   <= cfg_data[JCOST_W-1:0];
          default: ;
        endcase
      end
      if ((state_r == ST_PL_RD) || (state_r == ST_PL_WR)) begin
        k_r <= k_r + GRP_IDX_W'(1);
      end else begin
        k_r <= '0;
      end
      cap_v_r <= (state_r == ST_PL_RD);
      if (state_r == ST_UPDATE) begin
        if (best_sh > max_sh_r) max_sh_r <= best_sh;
        if (best_jn > max_jn_r) max_jn_r <= best_jn;
        sum_r <= (sum_wide > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];
      end
      if ((state_r == ST_OUT) && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unit_r  <= UNIT_W'(send_coef_r) * UNIT_W'(record_size_r);
    n_eff_r <= n_eff_nxt;
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    cap_k_r  <= k_r;
    cap_ok_r <= rec_ok[k_r];
    if (cap_v_r) begin
      rows_r[cap_k_r] <= cap_ok_r ? pm_rd_data : '0;
    end
    if (state_r == ST_UPDATE) begin
      added_r <= added;
    end
    if ((state_r == ST_OUT) && out_load) begin
      out_r.chosen_node      <= LNODE_W'(win_node);
      out_r.added_overhead   <= added_r;
      out_r.sum_overhead     <= sum_r;
      out_r.max_shuffle_load <= max_sh_r;
      out_r.max_join_load    <= max_jn_r;
    end
  end

  gjgp_presence_mem #(
    .MAX_NODES   (MAX_NODES),
    .NUM_RECORDS (NUM_RECORDS)
  ) u_presence (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (pm_rd_en),
    .rd_addr  (pm_rd_addr),
    .rd_data  (pm_rd_data),
    .wr_en    (pm_wr_en),
    .wr_addr  (pm_wr_addr),
    .wr_data  (pm_wr_data),
    .clr_busy (pm_clr_busy)
  );

  gjgp_load_mem #(
    .MAX_NODES (MAX_NODES)
  ) u_loads (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (lm_rd_addr),
    .rd_sh   (lm_rd_sh),
    .rd_jn   (lm_rd_jn),
    .wr_en   (lm_wr_en),
    .wr_addr (win_node),
    .wr_sh   (best_sh),
    .wr_jn   (best_jn)
  );

  gjgp_score_unit #(
    .MAX_NODES (MAX_NODES)
  ) u_score (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (score_start),
    .n_eff     (n_eff_r),
    .rows      (rows_r),
    .unit_cost (unit_r),
    .join_unit (join_unit_r),
    .max_sh    (max_sh_r),
    .max_jn    (max_jn_r),
    .ld_addr   (lm_rd_addr),
    .ld_sh     (lm_rd_sh),
    .ld_jn     (lm_rd_jn),
    .done      (score_done),
    .win_node  (win_node),
    .win_cost  (win_cost),
    .best_sh   (best_sh),
    .best_jn   (best_jn)
  );

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ design/gjgp_presence_mem.sv @@
// Presence map memory: one row of node bits per record, one write and one
// registered read port, and a clearing pass after reset.
// Depends on gjgp_pkg.
module gjgp_presence_mem
  import gjgp_pkg::*;
#(
  parameter int MAX_NODES   = 16,
  parameter int NUM_RECORDS = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           rd_en,
  input  logic [$clog2(NUM_RECORDS)-1:0] rd_addr,
  output logic [MAX_NODES-1:0]           rd_data,
  input  logic                           wr_en,
  input  logic [$clog2(NUM_RECORDS)-1:0] wr_addr,
  input  logic [MAX_NODES-1:0]           wr_data,
  output logic                           clr_busy
);

  localparam int AW = $clog2(NUM_RECORDS);

  logic [MAX_NODES-1:0] mem [NUM_RECORDS];
  logic [MAX_NODES-1:0] rd_data_r;
  logic [AW-1:0]        clr_addr_r;
  logic                 clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(NUM_RECORDS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

@@ design/gjgp_load_mem.sv @@
// Per-node planned shuffle and join loads, one write and one registered read
// port, with a valid bit per node so that unwritten nodes read as zero.
// Depends on gjgp_pkg.
module gjgp_load_mem
  import gjgp_pkg::*;
#(
  parameter int MAX_NODES = 16
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic [((MAX_NODES > 1) ? $clog2(MAX_NODES) : 1)-1:0] rd_addr,
  output logic [LOAD_W-1:0]                             rd_sh,
  output logic [LOAD_W-1:0]                             rd_jn,
  input  logic                                          wr_en,
  input  logic [((MAX_NODES > 1) ? $clog2(MAX_NODES) : 1)-1:0] wr_addr,
  input  logic [LOAD_W-1:0]                             wr_sh,
  input  logic [LOAD_W-1:0]                             wr_jn
);

  logic [LOAD_W-1:0]    sh_mem [MAX_NODES];
  logic [LOAD_W-1:0]    jn_mem [MAX_NODES];
  logic [MAX_NODES-1:0] vld_r;
  logic [LOAD_W-1:0]    rd_sh_r;
  logic [LOAD_W-1:0]    rd_jn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sh_mem[wr_addr] <= wr_sh;
      jn_mem[wr_addr] <= wr_jn;
    end
    rd_sh_r <= vld_r[rd_addr] ? sh_mem[rd_addr] : '0;
    rd_jn_r <= vld_r[rd_addr] ? jn_mem[rd_addr] : '0;
  end

  assign rd_sh = rd_sh_r;
  assign rd_jn = rd_jn_r;

endmodule

@@ design/gjgp_score_unit.sv @@
// Shared node scoring unit: a three-stage pipeline that scores one node per
// cycle and keeps the best node, its cost and its new loads.
// Depends on gjgp_pkg; reads node loads through gjgp_load_mem.
module gjgp_score_unit
  import gjgp_pkg::*;
#(
  parameter int MAX_NODES = 16
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          start,
  input  logic [$clog2(MAX_NODES+1)-1:0]                n_eff,
  input  logic [GROUP_SIZE-1:0][MAX_NODES-1:0]          rows,
  input  logic [UNIT_W-1:0]                             unit_cost,
  input  logic [JCOST_W-1:0]                            join_unit,
  input  logic [LOAD_W-1:0]                             max_sh,
  input  logic [LOAD_W-1:0]                             max_jn,
  output logic [((MAX_NODES > 1) ? $clog2(MAX_NODES) : 1)-1:0] ld_addr,
  input  logic [LOAD_W-1:0]                             ld_sh,
  input  logic [LOAD_W-1:0]                             ld_jn,
  output logic                                          done,
  output logic [((MAX_NODES > 1) ? $clog2(MAX_NODES) : 1)-1:0] win_node,
  output logic [COST_W-1:0]                             win_cost,
  output logic [LOAD_W-1:0]                             best_sh,
  output logic [LOAD_W-1:0]                             best_jn
);

  localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NCNT_W = $clog2(MAX_NODES + 1);

  logic              busy_r;
  logic [NCNT_W-1:0] iss_r;
  logic [NODE_W-1:0] node0;
  logic              last0;
  logic [MISS_W-1:0] miss0;
  logic [REC_COST_W-1:0] cost0;

  logic                  v1_r;
  logic                  last1_r;
  logic [NODE_W-1:0]     node1_r;
  logic [REC_COST_W-1:0] cost1_r;

  logic [COST_W-1:0] sum_sh1;
  logic [COST_W-1:0] sum_jn1;
  logic [LOAD_W-1:0] sh1;
  logic [LOAD_W-1:0] jn1;

  logic              v2_r;
  logic              last2_r;
  logic [NODE_W-1:0] node2_r;
  logic [LOAD_W-1:0] sh2_r;
  logic [LOAD_W-1:0] jn2_r;
  logic [LOAD_W-1:0] ds2_r;
  logic [LOAD_W-1:0] dj2_r;
  logic [COST_W-1:0] ov2;
  logic              take2;

  logic              done_r;
  logic [NODE_W-1:0] win_node_r;
  logic [COST_W-1:0] win_cost_r;
  logic [LOAD_W-1:0] best_sh_r;
  logic [LOAD_W-1:0] best_jn_r;

  assign node0 = NODE_W'(iss_r);
  assign last0 = (iss_r == n_eff - NCNT_W'(1));

  always_comb begin
    miss0 = '0;
    for (int k = 0; k < GROUP_SIZE; k++) begin
      if (!rows[k][node0]) begin
        miss0 = miss0 + MISS_W'(1);
      end
    end
  end

  assign cost0   = REC_COST_W'(miss0) * REC_COST_W'(unit_cost);
  assign ld_addr = node0;

  assign sum_sh1 = COST_W'(ld_sh) + COST_W'(cost1_r);
  assign sum_jn1 = COST_W'(ld_jn) + COST_W'(join_unit);
  assign sh1     = (sum_sh1 > COST_W'(LOAD_MAX)) ? LOAD_MAX : sum_sh1[LOAD_W-1:0];
  assign jn1     = (sum_jn1 > COST_W'(LOAD_MAX)) ? LOAD_MAX : sum_jn1[LOAD_W-1:0];

  assign ov2   = COST_W'(ds2_r) + COST_W'(dj2_r);
  assign take2 = v2_r && ((node2_r == '0) || (ov2 < win_cost_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      iss_r   <= '0;
      v1_r    <= 1'b0;
      last1_r <= 1'b0;
      v2_r    <= 1'b0;
      last2_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        iss_r  <= '0;
      end else if (busy_r) begin
        iss_r <= iss_r + NCNT_W'(1);
        if (last0) begin
          busy_r <= 1'b0;
        end
      end
      v1_r    <= busy_r;
      last1_r <= busy_r && last0;
      v2_r    <= v1_r;
      last2_r <= v1_r && last1_r;
      done_r  <= v2_r && last2_r;
    end
  end

  always_ff @(posedge clk) begin
    node1_r <= node0;
    cost1_r <= cost0;
    node2_r <= node1_r;
    sh2_r   <= sh1;
    jn2_r   <= jn1;
    ds2_r   <= (sh1 > max_sh) ? (sh1 - ld_sh) : '0;
    dj2_r   <= (jn1 > max_jn) ? (jn1 - ld_jn) : '0;
    if (take2) begin
      win_node_r <= node2_r;
      win_cost_r <= ov2;
      best_sh_r  <= sh2_r;
      best_jn_r  <= jn2_r;
    end
  end

  assign done     = done_r;
  assign win_node = win_node_r;
  assign win_cost = win_cost_r;
  assign best_sh  = best_sh_r;
  assign best_jn  = best_jn_r;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for greedy_join_group_placer: a queue-fed driver, a
// randomly stalling result receiver and a monitor that checks every placement.
// Depends on gjgp_pkg and the greedy_join_group_placer RTL.
module tb
  import gjgp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODE_CNT      = 16;
  localparam int REC_CNT       = 1024;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int PHASE_ITEMS   = 108;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  in_item_t  pending_items[$];
  out_item_t expected_placements[$];

  logic [NODE_CNT-1:0] presence [REC_CNT];
  logic [LOAD_W-1:0]   shuffle_load [NODE_CNT];
  logic [LOAD_W-1:0]   join_load [NODE_CNT];
  logic [LOAD_W-1:0]   peak_shuffle;
  logic [LOAD_W-1:0]   peak_join;
  logic [SUM_W-1:0]    overhead_total;
  logic [NCFG_W-1:0]   cfg_nodes;
  logic [COEF_W-1:0]   cfg_coef;
  logic [SIZE_W-1:0]   cfg_rec_size;
  logic [JCOST_W-1:0]  cfg_join_unit;

  int          err_cnt = 0;
  int          results_seen = 0;
  int          next_stall_at = 150;
  int          stall_left = 0;
  int          cycle_cnt = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic [9:0]  rec_base = '0;

  greedy_join_group_placer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [LOAD_W-1:0] sat_load(input logic [63:0] v);
    return (v > LOAD_MAX) ? LOAD_MAX : v[LOAD_W-1:0];
  endfunction

  task automatic predict_item(input in_item_t it);
    logic [REC_W-1:0] recs [GROUP_SIZE];
    int               n;
    int               best;
    int               missing;
    logic [63:0]      rec_cost, sh, jn, ov, win_cost, best_sh, best_jn, added, sum;
    out_item_t        res;
    if (it.op == OP_LOAD) begin
      presence[it.rec_a][it.load_node] = it.load_present;
      return;
    end
    recs = '{it.rec_a, it.rec_b, it.rec_c, it.rec_d, it.rec_e, it.rec_f, it.rec_g, it.rec_h};
    n = cfg_nodes;
    if (n < 1) n = 1;
    if (n > NODE_CNT) n = NODE_CNT;
    best = 0;
    win_cost = 0;
    best_sh = 0;
    best_jn = 0;
    for (int node = 0; node < n; node++) begin
      missing = 0;
      foreach (recs[k]) if (!presence[recs[k]][node]) missing++;
      rec_cost = 64'(missing) * cfg_coef * cfg_rec_size;
      sh = sat_load(64'(shuffle_load[node]) + rec_cost);
      jn = sat_load(64'(join_load[node]) + 64'(cfg_join_unit));
      ov = 0;
      if (jn > peak_join) ov += jn - join_load[node];
      if (sh > peak_shuffle) ov += sh - shuffle_load[node];
      if (node == 0 || ov < win_cost) begin
        best = node;
        win_cost = ov;
        best_sh = sh;
        best_jn = jn;
      end
    end
    foreach (recs[k]) presence[recs[k]][best] = 1'b1;
    added = (win_cost > LOAD_MAX) ? 64'(LOAD_MAX) : win_cost;
    sum = overhead_total + added;
    overhead_total = (sum > SUM_MAX) ? SUM_MAX : sum[SUM_W-1:0];
    shuffle_load[best] = best_sh[LOAD_W-1:0];
    join_load[best] = best_jn[LOAD_W-1:0];
    if (best_sh > peak_shuffle) peak_shuffle = best_sh[LOAD_W-1:0];
    if (best_jn > peak_join) peak_join = best_jn[LOAD_W-1:0];
    res.chosen_node = best[LNODE_W-1:0];
    res.added_overhead = added[LOAD_W-1:0];
    res.sum_overhead = overhead_total;
    res.max_shuffle_load = peak_shuffle;
    res.max_join_load = peak_join;
    expected_placements.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  task automatic check_placement(input out_item_t got);
    out_item_t want;
    if (expected_placements.size() == 0) begin
      $error("result with no placement pending: chosen_node %0d", got.chosen_node);
      err_cnt++;
      return;
    end
    want = expected_placements.pop_front();
    check_field("chosen_node", want.chosen_node, got.chosen_node);
    check_field("added_overhead", want.added_overhead, got.added_overhead);
    check_field("sum_overhead", want.sum_overhead, got.sum_overhead);
    check_field("max_shuffle_load", want.max_shuffle_load, got.max_shuffle_load);
    check_field("max_join_load", want.max_join_load, got.max_join_load);
  endtask

  // Results are checked before the item taken at the same edge is predicted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        check_placement(out_data);
        results_seen <= results_seen + 1;
      end
      if (in_valid && in_ready) predict_item(in_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // A long hold-off now and then lets the block fill up and stall its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (results_seen >= next_stall_at) begin
      stall_left <= 400;
      next_stall_at <= next_stall_at + 300;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic in_item_t load_of(input logic [REC_W-1:0] rec,
                                       input logic [LNODE_W-1:0] node,
                                       input logic present);
    in_item_t it;
    it = '0;
    it.op = OP_LOAD;
    it.rec_a = rec;
    it.load_node = node;
    it.load_present = present;
    return it;
  endfunction

  function automatic in_item_t place_of(input logic [REC_W-1:0] a, b, c, d, e, f, g, h);
    in_item_t it;
    it = '0;
    it.op = OP_PLACE;
    {it.rec_a, it.rec_b, it.rec_c, it.rec_d} = {a, b, c, d};
    {it.rec_e, it.rec_f, it.rec_g, it.rec_h} = {e, f, g, h};
    it.load_node = 4'hF;
    it.load_present = 1'b1;
    return it;
  endfunction

  function automatic logic [REC_W-1:0] pick_record();
    if ($urandom_range(99) < 70) return rec_base + REC_W'($urandom_range(23));
    return REC_W'($urandom_range(REC_CNT - 1));
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.op = ($urandom_range(99) < 35) ? OP_LOAD : OP_PLACE;
    it.rec_a = pick_record();
    it.rec_b = pick_record();
    it.rec_c = pick_record();
    it.rec_d = pick_record();
    it.rec_e = pick_record();
    it.rec_f = pick_record();
    it.rec_g = pick_record();
    it.rec_h = pick_record();
    it.load_node = LNODE_W'($urandom_range(NODE_CNT - 1));
    it.load_present = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_placements.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_NODES_IN_USE:   cfg_nodes = val[NCFG_W-1:0];
      CFG_SEND_COEF:      cfg_coef = val[COEF_W-1:0];
      CFG_RECORD_SIZE:    cfg_rec_size = val[SIZE_W-1:0];
      CFG_JOIN_UNIT_COST: cfg_join_unit = val[JCOST_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(input int nodes, input int coef, input int rsize, input int jcost);
    wait_idle();
    write_reg(CFG_NODES_IN_USE, CFG_DATA_W'(nodes));
    write_reg(CFG_SEND_COEF, CFG_DATA_W'(coef));
    write_reg(CFG_RECORD_SIZE, CFG_DATA_W'(rsize));
    write_reg(CFG_JOIN_UNIT_COST, CFG_DATA_W'(jcost));
    rec_base = REC_W'($urandom_range(REC_CNT - 1));
    repeat (PHASE_ITEMS) pending_items.push_back(random_item());
  endtask

  initial begin
    foreach (presence[r]) presence[r] = '0;
    foreach (shuffle_load[i]) begin
      shuffle_load[i] = '0;
      join_load[i] = '0;
    end
    peak_shuffle = '0;
    peak_join = '0;
    overhead_total = '0;
    cfg_nodes = 5'd16;
    cfg_coef = 8'd1;
    cfg_rec_size = 16'd1;
    cfg_join_unit = 16'd1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 13;
    recv_idle_pct = 76;
    pending_items.push_back(load_of(10'd0, 4'd0, 1'b1));
    pending_items.push_back(load_of(10'd1023, 4'd15, 1'b1));
    pending_items.push_back(load_of(10'd1023, 4'd0, 1'b1));
    pending_items.push_back(load_of(10'd1023, 4'd0, 1'b0));
    pending_items.push_back(load_of(10'd512, 4'd7, 1'b1));
    pending_items.push_back(place_of(0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(place_of(0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(place_of(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023));
    pending_items.push_back(place_of(0, 1, 2, 3, 4, 5, 6, 7));
    pending_items.push_back(place_of(10'h155, 10'h2AA, 10'h155, 10'h2AA, 0, 1023, 512, 511));
    pending_items.push_back(load_of(10'd0, 4'd15, 1'b0));
    pending_items.push_back(load_of(10'h2AA, 4'd8, 1'b1));
    pending_items.push_back(place_of(0, 0, 1023, 1023, 10'h2AA, 10'h2AA, 0, 1023));
    pending_items.push_back(place_of(5, 5, 5, 5, 5, 5, 5, 5));

    run_phase(31, 255, 65535, 65535);
    run_phase(0, 255, 65535, 0);
    send_idle_pct = 76;
    recv_idle_pct = 13;
    run_phase(16, 0, 0, 0);
    run_phase($urandom_range(2, 15), $urandom_range(1, 255), $urandom_range(0, 65535),
              $urandom_range(0, 65535));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(1, 1, 65535, 1);
    run_phase(16, 1, 1, 1);

    wait_idle();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/gjgp_pkg.sv
design/gjgp_presence_mem.sv
design/gjgp_load_mem.sv
design/gjgp_score_unit.sv
design/greedy_join_group_placer.sv
tb/tb.sv
